// File: src/msort_pkg.sv
package msort_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Control broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic                     ins;
		logic                     shift;
		logic signed [DATA_W-1:0] x;
	} cell_ctrl_t;

endpackage

// File: src/msort_cell.sv
module msort_cell
	import msort_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] prev_value,
	input  logic                     prev_valid,
	input  logic                     prev_ge,
	input  logic signed [DATA_W-1:0] next_value,
	input  logic                     next_valid,
	output logic signed [DATA_W-1:0] value,
	output logic                     valid,
	output logic                     ge
);

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;

	// An empty cell acts as plus infinity, so the new element lands before it.
	assign ge    = !valid_q || (ctrl.x < value_q);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.ins && ge) begin
			valid_q <= prev_ge ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
		end else if (ctrl.ins && ge) begin
			// The first cell whose content is larger takes the new element;
			// every cell behind it takes its neighbor's content.
			value_q <= prev_ge ? prev_value : ctrl.x;
		end
	end

endmodule

// File: src/merge_sort_engine_top.sv
// Loading takes one request per cycle; each element is placed in order on arrival.
// The first sorted result is offered in the cycle after the request flagged last is taken.
// Results then leave from the head of the cell chain, one per cycle while m_tready is high;
// input is held off while draining; elements past capacity only set the overflow flag.
// Asynchronous active-low reset empties the chain and clears count and overflow flag.
module merge_sort_engine_top
	import msort_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,   // is_last
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,   // end_of_run
	output logic              m_tuser    // overflowed
);

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             drain_q;
	logic             in_acc;
	logic             out_acc;
	logic             full;
	cell_ctrl_t       ctrl;

	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]      cell_vld;
	logic [CAPACITY-1:0]      cell_ge;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign s_tready = !drain_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = drain_q && cell_vld[0];
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = cell_val[0];
	assign m_tlast  = !cell_vld[1];
	assign m_tuser  = ovf_q;

	assign ctrl.ins   = in_acc && !full;
	assign ctrl.shift = out_acc;
	assign ctrl.x     = $signed(s_tdata);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [DATA_W-1:0] pv;
			logic signed [DATA_W-1:0] nv;
			logic                     pvld;
			logic                     pge;
			logic                     nvld;
			if (gi == 0) begin : g_head
				assign pv   = '0;
				assign pvld = 1'b0;
				assign pge  = 1'b0;
			end else begin : g_mid
				assign pv   = cell_val[gi-1];
				assign pvld = cell_vld[gi-1];
				assign pge  = cell_ge[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_tail
				assign nv   = '0;
				assign nvld = 1'b0;
			end else begin : g_body
				assign nv   = cell_val[gi+1];
				assign nvld = cell_vld[gi+1];
			end
			msort_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_value (pv),
				.prev_valid (pvld),
				.prev_ge    (pge),
				.next_value (nv),
				.next_valid (nvld),
				.value      (cell_val[gi]),
				.valid      (cell_vld[gi]),
				.ge         (cell_ge[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
		end else if (out_acc && m_tlast) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
		end else if (in_acc) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
			if (s_tlast) begin
				drain_q <= 1'b1;
			end
		end
	end

	a_no_load_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while results are pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count beyond capacity");

	a_cells_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> ($countones(cell_vld) == int'(count_q)))
		else $error("occupied cells disagree with element count");

	a_empty_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (count_q == '0 && !m_tvalid && cell_vld == '0))
		else $error("chain not empty after final result");

endmodule

// File: tb/merge_sort_engine_top_tb.sv
module merge_sort_engine_top_tb
	import msort_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 60;
	localparam int DRAIN_CYCLES  = 2 * CAPACITY + 16;

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
		logic              lost;
	} run_entry_t;

	// Keeps the open block sorted as it loads and queues the run it must produce.
	class sorted_run_tracker;
		elem_t      block_vals[CAPACITY];
		int         block_len;
		bit         block_lost;
		run_entry_t sorted_due[$];
		int         errors;
		int         results_seen;

		function new();
			block_len    = 0;
			block_lost   = 1'b0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void note_request(elem_t v, logic last);
			int         pos;
			run_entry_t e;
			if (block_len < CAPACITY) begin
				pos = block_len;
				while (pos > 0 && block_vals[pos-1] > v) begin
					block_vals[pos] = block_vals[pos-1];
					pos--;
				end
				block_vals[pos] = v;
				block_len++;
			end else begin
				// The store is full, so this element is dropped even when it closes the block.
				block_lost = 1'b1;
			end
			if (last) begin
				for (int k = 0; k < block_len; k++) begin
					e.value = block_vals[k];
					e.last  = (k == block_len - 1);
					e.lost  = block_lost;
					sorted_due.push_back(e);
				end
				block_len  = 0;
				block_lost = 1'b0;
			end
		endfunction

		task report(string what);
			errors++;
			$display("%0t ns: result %0d: %s", $realtime, results_seen, what);
		endtask

		task check_result(logic [DATA_W-1:0] d, logic l, logic u);
			run_entry_t e;
			if (sorted_due.size() == 0) begin
				report($sformatf("unexpected result %0d", $signed(d)));
			end else begin
				e = sorted_due.pop_front();
				if (d !== e.value)
					report($sformatf("sorted_value %0d, want %0d", $signed(d), $signed(e.value)));
				if (l !== e.last)
					report($sformatf("end_of_run %b, want %b", l, e.last));
				if (u !== e.lost)
					report($sformatf("overflowed %b, want %b", u, e.lost));
			end
			results_seen++;
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	sorted_run_tracker tracker;
	int                idle_pct;
	int                stall_pct;
	int                items_sent;

	merge_sort_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata, m_tlast, m_tuser);
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task send_element(elem_t v, logic last);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(v, last);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic elem_t pick_value();
		case ($urandom_range(0, 5))
			0: pick_value = $urandom_range(0, 1) ? elem_t'({1'b1, {(DATA_W-1){1'b0}}})
			                                    : elem_t'({1'b0, {(DATA_W-1){1'b1}}});
			1: pick_value = elem_t'($urandom_range(0, 8)) - elem_t'(4);
			default: pick_value = elem_t'($urandom);
		endcase
	endfunction

	task send_block(int n);
		for (int i = 0; i < n; i++)
			send_element(pick_value(), i == n - 1);
	endtask

	initial begin
		int    phase_start;
		int    blk;
		elem_t directed[$];
		int    sizes[$];
		int    at;

		tracker    = new();
		idle_pct   = 0;
		stall_pct  = 0;
		items_sent = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-element blocks at both extremes, then small blocks with ties and sign mixes.
		directed = '{32'h7fffffff, 32'h80000000,
		             32'h7fffffff, 32'h80000000,
		             32'h00000000, 32'hffffffff, 32'h00000001,
		             32'h00000005, 32'h00000005, 32'h00000005, 32'hfffffffb,
		             32'h00000001, 32'h7fffffff, 32'h80000000, 32'hffffffff,
		             32'haaaaaaaa, 32'h55555555};
		sizes = '{1, 1, 2, 3, 4, 6};
		at = 0;
		foreach (sizes[b]) begin
			for (int i = 0; i < sizes[b]; i++) begin
				send_element(directed[at], i == sizes[b] - 1);
				at++;
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			phase_start = items_sent;
			// The first three phases open with a full-size block: one past capacity with the
			// dropped element closing it, exactly capacity, and well past capacity.
			case (phase)
				0: send_block(CAPACITY + 1);
				1: send_block(CAPACITY);
				2: send_block(CAPACITY + 6);
				default: ;
			endcase
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 11) == 0)
					blk = $urandom_range(CAPACITY - 4, CAPACITY + 6);
				else
					blk = $urandom_range(1, 12);
				send_block(blk);
			end
		end
		s_tvalid <= 1'b0;

		while (tracker.sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("merge_sort_engine_top: match");
		else
			$display("merge_sort_engine_top: mismatch");
		$finish;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("merge_sort_engine_top: mismatch");
		$finish;
	end

endmodule
